/* rtl/fdec_pkg.sv */
package fdec_pkg;

    // Directory entry geometry.
    localparam int ENTRY_BYTES = 32;
    localparam int POS_W       = $clog2(ENTRY_BYTES);

    localparam logic [POS_W-1:0] POS_LEAD    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ATTR    = POS_W'(11);
    localparam logic [POS_W-1:0] POS_CLU_HI0 = POS_W'(20);
    localparam logic [POS_W-1:0] POS_CLU_HI1 = POS_W'(21);
    localparam logic [POS_W-1:0] POS_CLU_LO0 = POS_W'(26);
    localparam logic [POS_W-1:0] POS_CLU_LO1 = POS_W'(27);
    localparam logic [POS_W-1:0] POS_SIZE0   = POS_W'(28);
    localparam logic [POS_W-1:0] POS_SIZE1   = POS_W'(29);
    localparam logic [POS_W-1:0] POS_SIZE2   = POS_W'(30);
    localparam logic [POS_W-1:0] POS_SIZE3   = POS_W'(31);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(ENTRY_BYTES - 1);

    // Marker bytes and attribute bits.
    localparam logic [7:0] LEAD_END     = 8'h00;
    localparam logic [7:0] LEAD_DELETED = 8'hE5;
    localparam logic [7:0] LEAD_DOT     = 8'h2E;
    localparam logic [7:0] ATTR_LFN     = 8'h0F;
    localparam int         ATTR_VOL_BIT = 3;
    localparam int         ATTR_DIR_BIT = 4;

    // Configuration register map.
    localparam int         CFG_ADDR_W       = 3;
    localparam logic       CFG_IDX_TOTAL    = 1'b0;
    localparam logic       CFG_IDX_LOG2     = 1'b1;
    localparam logic [27:0] TOTAL_RESET     = 28'd0;
    localparam logic [4:0]  LOG2_RESET      = 5'd12;

    localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

    typedef enum logic [3:0] {
        KIND_FILE    = 4'd0,
        KIND_SUBDIR  = 4'd1,
        KIND_END     = 4'd2,
        KIND_DELETED = 4'd3,
        KIND_LFN     = 4'd4,
        KIND_VOLUME  = 4'd5,
        KIND_BADCLU  = 4'd6,
        KIND_EMPTY   = 4'd7,
        KIND_DOT     = 4'd8
    } t_entry_kind;

    typedef struct packed {
        logic [7:0] dir_byte;
        logic       dir_start;
    } t_in_item;

    typedef struct packed {
        t_entry_kind entry_kind;
        logic [31:0] first_cluster;
        logic [31:0] file_size;
        logic [23:0] cluster_count;
    } t_out_item;

endpackage

/* rtl/fdec_classify.sv */
module fdec_classify (
    input  logic [7:0]          i_lead,
    input  logic [7:0]          i_attr,
    input  logic [31:0]         i_cluster,
    input  logic [31:0]         i_size,
    input  logic [27:0]         i_cluster_total,
    input  logic [4:0]          i_cluster_size_log2,
    output fdec_pkg::t_out_item o_result
);
    import fdec_pkg::*;

    logic        bad_cluster;
    logic [31:0] cluster_limit;
    logic [31:0] quotient;
    logic [31:0] rem_mask;
    logic        rem_nz;
    logic [32:0] count_wide;
    t_entry_kind kind;

    // The limit is at most 2^28 + 1, so it never wraps in 32 bits.
    assign cluster_limit = 32'(i_cluster_total) + 32'd2;
    assign bad_cluster   = (i_cluster < 32'd2) || (i_cluster >= cluster_limit);

    always_comb begin
        priority if (i_lead == LEAD_END) begin
            kind = KIND_END;
        end else if (i_lead == LEAD_DELETED) begin
            kind = KIND_DELETED;
        end else if (i_attr == ATTR_LFN) begin
            kind = KIND_LFN;
        end else if (i_attr[ATTR_VOL_BIT]) begin
            kind = KIND_VOLUME;
        end else if (bad_cluster) begin
            kind = KIND_BADCLU;
        end else if (!i_attr[ATTR_DIR_BIT]) begin
            kind = (i_size == 32'd0) ? KIND_EMPTY : KIND_FILE;
        end else begin
            kind = (i_lead == LEAD_DOT) ? KIND_DOT : KIND_SUBDIR;
        end
    end

    // Round up by adding one when any bit below the shift point is set.
    assign quotient   = i_size >> i_cluster_size_log2;
    assign rem_mask   = ~(32'hFFFF_FFFF << i_cluster_size_log2);
    assign rem_nz     = |(i_size & rem_mask);
    assign count_wide = {1'b0, quotient} + 33'(rem_nz);

    assign o_result.entry_kind    = kind;
    assign o_result.first_cluster = i_cluster;
    assign o_result.file_size     = i_size;
    assign o_result.cluster_count = (|count_wide[32:24]) ? COUNT_MAX : count_wide[23:0];

endmodule

/* rtl/fat_dir_entry_classifier.sv */
// FAT directory entry classifier.
//
// The input channel carries one directory byte per transaction, with a flag
// that marks the first byte of a new directory. Every 32 bytes form one
// directory entry; the transaction that carries an entry's last byte yields
// one result transaction on the output channel with the entry's kind, start
// cluster, file size and rounded-up cluster count. Other bytes yield none.
// After an end-of-directory entry, bytes are dropped until one arrives with
// the start flag set.
//
// Results are registered: a finished entry's result goes into the result register
// when that register is empty or being emptied, else into the skid register. Input
// is one byte per cycle while o_in_ready is high. When the receiver stalls, one
// further result is held in a skid register; o_in_ready falls only once that
// register is also full, and it is driven from a flop, not from i_out_ready.
//
// Reset clears the byte position, the captured fields, the end flag and both
// result slots, and returns the registers to a cluster total of 0 and a
// cluster size log2 of 12. Configuration is written through the APB port.
module fat_dir_entry_classifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Byte stream.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  fdec_pkg::t_in_item                 i_in_data,
    // Results.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output fdec_pkg::t_out_item                o_out_data,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fdec_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import fdec_pkg::*;

    // Configuration registers.
    logic [27:0] r_cluster_total;
    logic [4:0]  r_cluster_size_log2;
    logic        cfg_write;

    // Parser state.
    logic [POS_W-1:0] r_pos,     n_pos;
    logic             r_ended,   n_ended;
    logic [7:0]       r_lead,    n_lead;
    logic [7:0]       r_attr,    n_attr;
    logic [31:0]      r_cluster, n_cluster;
    logic [31:0]      r_size,    n_size;

    // Result register and skid register.
    logic      r_out_valid,  n_out_valid;
    t_out_item r_out_data,   n_out_data;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_skid_data,  n_skid_data;

    logic             in_accept;
    logic [POS_W-1:0] pos_eff;
    logic             ended_eff;
    logic             entry_done;
    logic             out_pop;
    t_out_item        result;

    // ------------------------------------------------------------------
    // Configuration port. Only one address bit selects a register, so
    // every write lands in one of the two.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_total     <= TOTAL_RESET;
            r_cluster_size_log2 <= LOG2_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                CFG_IDX_TOTAL: r_cluster_total     <= pwdata[27:0];
                CFG_IDX_LOG2:  r_cluster_size_log2 <= pwdata[4:0];
                default:       r_cluster_total     <= r_cluster_total;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_IDX_TOTAL: prdata = {4'd0, r_cluster_total};
            CFG_IDX_LOG2:  prdata = {27'd0, r_cluster_size_log2};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Byte capture. The start flag restarts the position and clears the
    // end flag before the byte itself is looked at.
    // ------------------------------------------------------------------
    assign o_in_ready = !r_skid_valid;
    assign in_accept  = i_in_valid && o_in_ready;
    assign pos_eff    = i_in_data.dir_start ? POS_LEAD : r_pos;
    assign ended_eff  = i_in_data.dir_start ? 1'b0 : r_ended;

    always_comb begin
        n_lead    = r_lead;
        n_attr    = r_attr;
        n_cluster = r_cluster;
        n_size    = r_size;
        unique case (pos_eff)
            POS_LEAD:    n_lead           = i_in_data.dir_byte;
            POS_ATTR:    n_attr           = i_in_data.dir_byte;
            POS_CLU_HI0: n_cluster[23:16] = i_in_data.dir_byte;
            POS_CLU_HI1: n_cluster[31:24] = i_in_data.dir_byte;
            POS_CLU_LO0: n_cluster[7:0]   = i_in_data.dir_byte;
            POS_CLU_LO1: n_cluster[15:8]  = i_in_data.dir_byte;
            POS_SIZE0:   n_size[7:0]      = i_in_data.dir_byte;
            POS_SIZE1:   n_size[15:8]     = i_in_data.dir_byte;
            POS_SIZE2:   n_size[23:16]    = i_in_data.dir_byte;
            POS_SIZE3:   n_size[31:24]    = i_in_data.dir_byte;
            default:     n_lead           = r_lead;
        endcase
    end

    assign entry_done = in_accept && !ended_eff && (pos_eff == POS_LAST);

    // The end rule depends only on the lead byte, which was captured long
    // before the entry's last byte.
    always_comb begin
        n_pos   = r_pos;
        n_ended = r_ended;
        if (in_accept) begin
            n_pos   = pos_eff;
            n_ended = ended_eff;
            if (!ended_eff) begin
                n_pos = (pos_eff == POS_LAST) ? POS_LEAD : pos_eff + POS_W'(1);
                if (pos_eff == POS_LAST && n_lead == LEAD_END) begin
                    n_ended = 1'b1;
                end
            end
        end
    end

    fdec_classify u_classify (
        .i_lead              (n_lead),
        .i_attr              (n_attr),
        .i_cluster           (n_cluster),
        .i_size              (n_size),
        .i_cluster_total     (r_cluster_total),
        .i_cluster_size_log2 (r_cluster_size_log2),
        .o_result            (result)
    );

    // ------------------------------------------------------------------
    // Result register with a skid register behind it. A new result only
    // arrives while the skid register is empty.
    // ------------------------------------------------------------------
    assign out_pop = r_out_valid && i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (out_pop) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (entry_done) begin
            if (!r_out_valid || out_pop) begin
                n_out_valid = 1'b1;
                n_out_data  = result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = result;
            end
        end else if (out_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_LEAD;
            r_ended      <= 1'b0;
            r_lead       <= 8'd0;
            r_attr       <= 8'd0;
            r_cluster    <= 32'd0;
            r_size       <= 32'd0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_ended      <= n_ended;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (in_accept && !ended_eff) begin
                r_lead    <= n_lead;
                r_attr    <= n_attr;
                r_cluster <= n_cluster;
                r_size    <= n_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/fdec_checker.sv */
module fdec_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input fdec_pkg::t_out_item o_out_data
);
    import fdec_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    a_empty_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.entry_kind == KIND_EMPTY
            |-> o_out_data.file_size == 32'd0)
        else $error("empty entry with nonzero size");

    a_file_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.entry_kind == KIND_FILE
            |-> o_out_data.file_size != 32'd0)
        else $error("file entry with zero size");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.file_size != 32'd0
            |-> o_out_data.cluster_count != 24'd0)
        else $error("nonzero size rounded to zero clusters");

endmodule

bind fat_dir_entry_classifier fdec_checker u_fdec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
